// ===== rtl/bca_pkg.sv =====
package bca_pkg;

    // Table geometry.
    localparam int NUM_BLOCKS = 1024;
    localparam int BLK_W      = $clog2(NUM_BLOCKS);
    localparam int LINK_W     = BLK_W + 1;
    localparam int WORD_W     = 32;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int WORDS      = NUM_BLOCKS / WORD_W;
    localparam int WADDR_W    = BLK_W - BIT_W;

    // End-of-chain link value.
    localparam logic [LINK_W-1:0] LINK_END = LINK_W'(NUM_BLOCKS);

    // Operation codes.
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_SEEK  = 2'd1;
    localparam logic [1:0] OP_CUT   = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_END     = 2'd2;

    // Commands from the controller to the datapath.
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CLR_WR,
        CMD_LOAD,
        CMD_SCAN_INIT,
        CMD_SCAN_RD,
        CMD_SCAN_NEXT,
        CMD_TAKE,
        CMD_ALLOC_OK,
        CMD_HEAD_FB,
        CMD_LINK_WR,
        CMD_SET_ST1,
        CMD_SET_ST1_CUR,
        CMD_SET_ST2,
        CMD_SET_ST2_CUR,
        CMD_BLK_CUR,
        CMD_STEP,
        CMD_CUT_INIT0,
        CMD_CUT_INIT,
        CMD_CUT_TAIL,
        CMD_FREE_RD,
        CMD_FREE_WR
    } bca_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       has_head;
        logic       grow;
        logic       count_zero;
        logic       i_eq_count;
        logic       nx_end;
        logic       word_full;
        logic       w_last;
        logic       cur_end;
        logic       freed_max;
    } bca_stat_t;

    // Index of the lowest zero bit of a used-mark word.
    function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] d);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int k = WORD_W - 1; k >= 0; k--)
        begin
            if (!d[k])
            begin
                idx = BIT_W'(k);
            end
        end
        return idx;
    endfunction

endpackage

// ===== rtl/bca_ram.sv =====
module bca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/bca_datapath.sv =====
module bca_datapath import bca_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  bca_cmd_t          cmd,
    input  logic [1:0]        op,
    input  logic [BLK_W-1:0]  head_block,
    input  logic              head_present,
    input  logic [LINK_W-1:0] count,
    input  logic              grow,
    output bca_stat_t         stat,
    output logic [1:0]        status,
    output logic [BLK_W-1:0]  block_id,
    output logic [BLK_W-1:0]  new_head,
    output logic              new_head_present,
    output logic [LINK_W-1:0] freed_count
);

    logic [1:0]         op_reg;
    logic               grow_reg;
    logic               present_reg;
    logic [LINK_W-1:0]  count_reg;
    logic [LINK_W-1:0]  cur_reg;
    logic [LINK_W-1:0]  i_reg;
    logic [BLK_W-1:0]   fb_reg;
    logic [WADDR_W-1:0] w_reg;
    logic [1:0]         status_reg;
    logic [BLK_W-1:0]   blk_reg;
    logic [BLK_W-1:0]   head_reg;
    logic               head_present_reg;
    logic [LINK_W-1:0]  freed_reg;

    logic               used_we;
    logic [WADDR_W-1:0] used_waddr;
    logic [WORD_W-1:0]  used_wdata;
    logic [WADDR_W-1:0] used_raddr;
    logic [WORD_W-1:0]  used_rdata;
    logic               link_we;
    logic [BLK_W-1:0]   link_waddr;
    logic [LINK_W-1:0]  link_wdata;
    logic [LINK_W-1:0]  link_rdata;
    logic [LINK_W-1:0]  nx;
    logic [BIT_W-1:0]   zero_bit;
    logic [BLK_W-1:0]   take_blk;

    // Link read always follows the current block; out-of-range links end the chain.
    assign nx       = link_rdata[LINK_W-1] ? LINK_END : link_rdata;
    assign zero_bit = first_zero(used_rdata);
    assign take_blk = {w_reg, zero_bit};

    // Memory port control.
    always_comb
    begin
        used_we    = 1'b0;
        used_waddr = w_reg;
        used_wdata = '0;
        used_raddr = (cmd == CMD_SCAN_RD) ? w_reg : cur_reg[BLK_W-1:BIT_W];
        link_we    = 1'b0;
        link_waddr = cur_reg[BLK_W-1:0];
        link_wdata = LINK_END;
        case (cmd)
            CMD_CLR_WR:
            begin
                used_we = 1'b1;
            end
            CMD_TAKE:
            begin
                used_we    = 1'b1;
                used_wdata = used_rdata | (WORD_W'(1) << zero_bit);
                link_we    = 1'b1;
                link_waddr = take_blk;
            end
            CMD_LINK_WR:
            begin
                link_we    = 1'b1;
                link_wdata = {1'b0, fb_reg};
            end
            CMD_CUT_TAIL:
            begin
                link_we = 1'b1;
            end
            CMD_FREE_WR:
            begin
                used_we    = 1'b1;
                used_waddr = cur_reg[BLK_W-1:BIT_W];
                used_wdata = used_rdata & ~(WORD_W'(1) << cur_reg[BIT_W-1:0]);
                link_we    = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    bca_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_used (
        .clk   (clk),
        .we    (used_we),
        .waddr (used_waddr),
        .wdata (used_wdata),
        .raddr (used_raddr),
        .rdata (used_rdata)
    );

    bca_ram #(.WIDTH(LINK_W), .DEPTH(NUM_BLOCKS)) u_link (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (cur_reg[BLK_W-1:0]),
        .rdata (link_rdata)
    );

    // Word counter for the clearing pass and the free-block scan.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= '0;
        end
        else if (cmd == CMD_SCAN_INIT)
        begin
            w_reg <= '0;
        end
        else if (cmd == CMD_CLR_WR || cmd == CMD_SCAN_NEXT)
        begin
            w_reg <= w_reg + 1'b1;
        end
    end

    // Request and result registers.
    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LOAD:
            begin
                op_reg           <= op;
                grow_reg         <= grow;
                present_reg      <= head_present;
                count_reg        <= count;
                cur_reg          <= {1'b0, head_block};
                i_reg            <= '0;
                freed_reg        <= '0;
                status_reg       <= ST_OK;
                blk_reg          <= '0;
                head_reg         <= head_present ? head_block : '0;
                head_present_reg <= head_present;
            end
            CMD_TAKE:
            begin
                fb_reg <= take_blk;
            end
            CMD_ALLOC_OK:
            begin
                blk_reg <= fb_reg;
            end
            CMD_HEAD_FB:
            begin
                cur_reg          <= {1'b0, fb_reg};
                i_reg            <= '0;
                head_reg         <= fb_reg;
                head_present_reg <= 1'b1;
            end
            CMD_LINK_WR:
            begin
                cur_reg <= {1'b0, fb_reg};
                i_reg   <= i_reg + 1'b1;
            end
            CMD_SET_ST1:
            begin
                status_reg <= ST_NOSPACE;
            end
            CMD_SET_ST1_CUR:
            begin
                status_reg <= ST_NOSPACE;
                blk_reg    <= cur_reg[BLK_W-1:0];
            end
            CMD_SET_ST2:
            begin
                status_reg <= ST_END;
            end
            CMD_SET_ST2_CUR:
            begin
                status_reg <= ST_END;
                blk_reg    <= cur_reg[BLK_W-1:0];
            end
            CMD_BLK_CUR:
            begin
                blk_reg <= cur_reg[BLK_W-1:0];
            end
            CMD_STEP:
            begin
                cur_reg <= nx;
                i_reg   <= i_reg + 1'b1;
            end
            CMD_CUT_INIT0:
            begin
                head_reg         <= '0;
                head_present_reg <= 1'b0;
            end
            CMD_CUT_INIT:
            begin
                i_reg <= LINK_W'(1);
            end
            CMD_CUT_TAIL:
            begin
                cur_reg <= nx;
            end
            CMD_FREE_WR:
            begin
                cur_reg   <= nx;
                freed_reg <= freed_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Status toward the controller.
    assign stat.op         = op_reg;
    assign stat.has_head   = present_reg;
    assign stat.grow       = grow_reg;
    assign stat.count_zero = (count_reg == '0);
    assign stat.i_eq_count = (i_reg == count_reg);
    assign stat.nx_end     = link_rdata[LINK_W-1];
    assign stat.word_full  = &used_rdata;
    assign stat.w_last     = (w_reg == WADDR_W'(WORDS - 1));
    assign stat.cur_end    = cur_reg[LINK_W-1];
    assign stat.freed_max  = (freed_reg == LINK_W'(NUM_BLOCKS));

    assign status           = status_reg;
    assign block_id         = blk_reg;
    assign new_head         = head_reg;
    assign new_head_present = head_present_reg;
    assign freed_count      = freed_reg;

endmodule

// ===== rtl/bca_ctrl.sv =====
module bca_ctrl import bca_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  bca_stat_t stat,
    output bca_cmd_t  cmd,
    output logic      busy,
    output logic      done
);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DISP, S_SCAN_RD, S_SCAN_CHK, S_TAKEN,
        S_SEEK, S_SEEK_WAIT, S_CUT_WALK, S_CUT_WAIT, S_TAIL_WAIT,
        S_FREE, S_FREE_WR
    } state_t;

    typedef enum logic [1:0] {
        T_ALLOC, T_HEAD, T_GROW
    } target_t;

    state_t  state_reg, state_next;
    target_t tgt_reg, tgt_next;
    logic    done_reg, done_next;

    // Next state and the command for this cycle.
    always_comb
    begin
        state_next = state_reg;
        tgt_next   = tgt_reg;
        done_next  = 1'b0;
        cmd        = CMD_NONE;
        case (state_reg)
            S_CLR:
            begin
                cmd = CMD_CLR_WR;
                if (stat.w_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                case (stat.op)
                    OP_ALLOC:
                    begin
                        cmd        = CMD_SCAN_INIT;
                        tgt_next   = T_ALLOC;
                        state_next = S_SCAN_RD;
                        done_next  = 1'b0;
                    end
                    OP_SEEK:
                    begin
                        if (stat.has_head)
                        begin
                            state_next = S_SEEK;
                            done_next  = 1'b0;
                        end
                        else if (stat.grow)
                        begin
                            cmd        = CMD_SCAN_INIT;
                            tgt_next   = T_HEAD;
                            state_next = S_SCAN_RD;
                            done_next  = 1'b0;
                        end
                        else
                        begin
                            cmd = CMD_SET_ST2;
                        end
                    end
                    OP_CUT:
                    begin
                        if (stat.has_head && stat.count_zero)
                        begin
                            cmd        = CMD_CUT_INIT0;
                            state_next = S_FREE;
                            done_next  = 1'b0;
                        end
                        else if (stat.has_head)
                        begin
                            cmd        = CMD_CUT_INIT;
                            state_next = S_CUT_WALK;
                            done_next  = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                cmd        = CMD_SCAN_RD;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (!stat.word_full)
                begin
                    cmd        = CMD_TAKE;
                    state_next = S_TAKEN;
                end
                else if (stat.w_last)
                begin
                    cmd        = (tgt_reg == T_GROW) ? CMD_SET_ST1_CUR : CMD_SET_ST1;
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    cmd        = CMD_SCAN_NEXT;
                    state_next = S_SCAN_RD;
                end
            end
            S_TAKEN:
            begin
                case (tgt_reg)
                    T_HEAD:
                    begin
                        cmd        = CMD_HEAD_FB;
                        state_next = S_SEEK;
                    end
                    T_GROW:
                    begin
                        cmd        = CMD_LINK_WR;
                        state_next = S_SEEK;
                    end
                    default:
                    begin
                        cmd        = CMD_ALLOC_OK;
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                    end
                endcase
            end
            S_SEEK:
            begin
                if (stat.i_eq_count)
                begin
                    cmd        = CMD_BLK_CUR;
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    state_next = S_SEEK_WAIT;
                end
            end
            S_SEEK_WAIT:
            begin
                if (!stat.nx_end)
                begin
                    cmd        = CMD_STEP;
                    state_next = S_SEEK;
                end
                else if (!stat.grow)
                begin
                    cmd        = CMD_SET_ST2_CUR;
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    cmd        = CMD_SCAN_INIT;
                    tgt_next   = T_GROW;
                    state_next = S_SCAN_RD;
                end
            end
            S_CUT_WALK:
            begin
                state_next = stat.i_eq_count ? S_TAIL_WAIT : S_CUT_WAIT;
            end
            S_CUT_WAIT:
            begin
                if (stat.nx_end)
                begin
                    state_next = S_TAIL_WAIT;
                end
                else
                begin
                    cmd        = CMD_STEP;
                    state_next = S_CUT_WALK;
                end
            end
            S_TAIL_WAIT:
            begin
                cmd        = CMD_CUT_TAIL;
                state_next = S_FREE;
            end
            S_FREE:
            begin
                if (stat.cur_end || stat.freed_max)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    cmd        = CMD_FREE_RD;
                    state_next = S_FREE_WR;
                end
            end
            S_FREE_WR:
            begin
                cmd        = CMD_FREE_WR;
                state_next = S_FREE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            tgt_reg   <= T_ALLOC;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tgt_reg   <= tgt_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// ===== rtl/block_chain_allocator_core.sv =====
// Channel   Transfer when        Payload
// request   start && !busy       op, head_block, head_present, count, grow
// result    done (one cycle)     status, block_id, new_head, new_head_present,
//                                freed_count
//
// After reset a pass clears the used marks word by word; busy is high meanwhile.
// A free-block search reads one 32-block word of used marks at a time, in states
// S_SCAN_RD and S_SCAN_CHK. Each link followed is one read of the link memory,
// and each block freed by a cut passes through S_FREE and S_FREE_WR.
// One request is worked at a time; done pulses as busy falls and cannot be held.
module block_chain_allocator_core import bca_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        op,
    input  logic [BLK_W-1:0]  head_block,
    input  logic              head_present,
    input  logic [LINK_W-1:0] count,
    input  logic              grow,
    output logic              done,
    output logic [1:0]        status,
    output logic [BLK_W-1:0]  block_id,
    output logic [BLK_W-1:0]  new_head,
    output logic              new_head_present,
    output logic [LINK_W-1:0] freed_count
);

    bca_cmd_t  cmd;
    bca_stat_t stat;

    // Sequencer.
    bca_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Block table and result registers.
    bca_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .op               (op),
        .head_block       (head_block),
        .head_present     (head_present),
        .count            (count),
        .grow             (grow),
        .stat             (stat),
        .status           (status),
        .block_id         (block_id),
        .new_head         (new_head),
        .new_head_present (new_head_present),
        .freed_count      (freed_count)
    );

    // A result appears only once the block is free again.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");

    // An accepted request always occupies the block next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done)) else $error("request not taken");

    // Only defined status codes are reported.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_OK || status == ST_NOSPACE || status == ST_END))
        else $error("bad status code");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import bca_pkg::*;

    // The one operation code the block leaves unused.
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef struct {
        logic [1:0]        st;
        logic [BLK_W-1:0]  blk;
        logic [BLK_W-1:0]  hd;
        logic              hp;
        logic [LINK_W-1:0] freed;
    } chain_result_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        op;
    logic [BLK_W-1:0]  head_block;
    logic              head_present;
    logic [LINK_W-1:0] count;
    logic              grow;
    logic              done;
    logic [1:0]        status;
    logic [BLK_W-1:0]  block_id;
    logic [BLK_W-1:0]  new_head;
    logic              new_head_present;
    logic [LINK_W-1:0] freed_count;

    // Shadow copy of the block table.
    bit            used_mark [NUM_BLOCKS];
    int            chain_link [NUM_BLOCKS];
    bit            ever_taken [NUM_BLOCKS];
    chain_result_t pending_results [$];
    int            known_heads [$];
    int            error_count;

    block_chain_allocator_core u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .op               (op),
        .head_block       (head_block),
        .head_present     (head_present),
        .count            (count),
        .grow             (grow),
        .done             (done),
        .status           (status),
        .block_id         (block_id),
        .new_head         (new_head),
        .new_head_present (new_head_present),
        .freed_count      (freed_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Lowest free block, marked used with its chain ended.
    function automatic int grab_block();
        for (int i = 0; i < NUM_BLOCKS; i++)
        begin
            if (!used_mark[i])
            begin
                used_mark[i]  = 1'b1;
                chain_link[i] = NUM_BLOCKS;
                ever_taken[i] = 1'b1;
                return i;
            end
        end
        return NUM_BLOCKS;
    endfunction

    // Expected result of one request; updates the shadow table.
    function automatic chain_result_t predict_request(logic [1:0] o, logic [BLK_W-1:0] h,
                                                     logic p, logic [LINK_W-1:0] c, logic g);
        chain_result_t r;
        int            cur;
        int            nx;
        int            keep;
        bit            ok;
        r.st    = ST_OK;
        r.blk   = '0;
        r.hd    = p ? h : '0;
        r.hp    = p;
        r.freed = '0;
        if (o == OP_ALLOC)
        begin
            nx = grab_block();
            if (nx == NUM_BLOCKS)
                r.st = ST_NOSPACE;
            else
                r.blk = BLK_W'(nx);
        end
        else if (o == OP_SEEK)
        begin
            cur = int'(h);
            ok  = p;
            if (!p)
            begin
                if (g)
                begin
                    nx = grab_block();
                    if (nx == NUM_BLOCKS)
                        r.st = ST_NOSPACE;
                    else
                    begin
                        cur  = nx;
                        ok   = 1'b1;
                        r.hd = BLK_W'(nx);
                        r.hp = 1'b1;
                    end
                end
                else
                    r.st = ST_END;
            end
            if (ok)
            begin
                for (int i = 0; i < c; i++)
                begin
                    nx = chain_link[cur];
                    if (nx == NUM_BLOCKS)
                    begin
                        if (!g)
                        begin
                            r.st = ST_END;
                            break;
                        end
                        nx = grab_block();
                        if (nx == NUM_BLOCKS)
                        begin
                            r.st = ST_NOSPACE;
                            break;
                        end
                        chain_link[cur] = nx;
                    end
                    cur = nx;
                end
                r.blk = BLK_W'(cur);
            end
        end
        else if (o == OP_CUT && p)
        begin
            if (c == 0)
            begin
                cur  = int'(h);
                r.hd = '0;
                r.hp = 1'b0;
            end
            else
            begin
                keep = int'(h);
                for (int i = 1; i < c; i++)
                begin
                    nx = chain_link[keep];
                    if (nx == NUM_BLOCKS)
                        break;
                    keep = nx;
                end
                cur = chain_link[keep];
                chain_link[keep] = NUM_BLOCKS;
            end
            for (int i = 0; i < NUM_BLOCKS && cur != NUM_BLOCKS; i++)
            begin
                nx = chain_link[cur];
                used_mark[cur]  = 1'b0;
                chain_link[cur] = NUM_BLOCKS;
                r.freed++;
                cur = nx;
            end
        end
        return r;
    endfunction

    // Sends one request after a random gap and records its expected result.
    task automatic send_request(logic [1:0] o, logic [BLK_W-1:0] h, logic p,
                                logic [LINK_W-1:0] c, logic g);
        int            gap;
        chain_result_t r;
        gap = $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        op           <= o;
        head_block   <= h;
        head_present <= p;
        count        <= c;
        grow         <= g;
        do
            @(posedge clk);
        while (busy);
        r = predict_request(o, h, p, c, g);
        pending_results.push_back(r);
        if (o == OP_SEEK && !p && g && r.hp)
            known_heads.push_back(r.hd);
        if (known_heads.size() > 24)
            void'(known_heads.pop_front());
    endtask

    // Holds the request side idle until every expected result has come.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Each result transfer is compared with the oldest expectation.
    always @(posedge clk)
    begin
        chain_result_t e;
        if (done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d block=%0d", $time, status,
                         block_id);
                error_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                    error_count++;
                end
                if (block_id !== e.blk)
                begin
                    $display("%0t: block_id expected %0d actual %0d", $time, e.blk,
                             block_id);
                    error_count++;
                end
                if (new_head !== e.hd)
                begin
                    $display("%0t: new_head expected %0d actual %0d", $time, e.hd, new_head);
                    error_count++;
                end
                if (new_head_present !== e.hp)
                begin
                    $display("%0t: new_head_present expected %0d actual %0d", $time, e.hp,
                             new_head_present);
                    error_count++;
                end
                if (freed_count !== e.freed)
                begin
                    $display("%0t: freed_count expected %0d actual %0d", $time, e.freed,
                             freed_count);
                    error_count++;
                end
            end
        end
    end

    // Each operation and the edge cases on a fresh table.
    task automatic test_directed();
        send_request(OP_ALLOC, 10'd0, 1'b0, 11'd0, 1'b0);
        send_request(OP_SEEK, 10'd1023, 1'b0, 11'd3, 1'b1);
        send_request(OP_SEEK, 10'd0, 1'b1, 11'd0, 1'b1);
        send_request(OP_SEEK, 10'd1, 1'b1, 11'd2, 1'b0);
        send_request(OP_SEEK, 10'd1, 1'b1, 11'd9, 1'b0);
        send_request(OP_SEEK, 10'd1023, 1'b0, 11'd1, 1'b0);
        send_request(OP_SEEK, 10'd1, 1'b1, 11'd5, 1'b1);
        send_request(OP_CUT, 10'd1, 1'b1, 11'd2, 1'b0);
        send_request(OP_CUT, 10'd1, 1'b1, 11'd40, 1'b1);
        send_request(OP_CUT, 10'd512, 1'b0, 11'd0, 1'b0);
        send_request(OP_NONE, 10'd1023, 1'b1, 11'd1024, 1'b1);
        send_request(OP_NONE, 10'd0, 1'b0, 11'd0, 1'b0);
        send_request(OP_CUT, 10'd1, 1'b1, 11'd0, 1'b0);
        // Fill the table, then run out of space.
        send_request(OP_SEEK, 10'd0, 1'b0, 11'd1024, 1'b1);
        send_request(OP_ALLOC, 10'd1023, 1'b1, 11'd2047, 1'b1);
        send_request(OP_SEEK, 10'd0, 1'b0, 11'd1, 1'b1);
        send_request(OP_SEEK, 10'd0, 1'b1, 11'd3, 1'b1);
        send_request(OP_CUT, 10'd2, 1'b1, 11'd1024, 1'b0);
        send_request(OP_CUT, 10'd0, 1'b1, 11'd1, 1'b0);
        send_request(OP_CUT, 10'd2, 1'b1, 11'd0, 1'b0);
        send_request(OP_SEEK, 10'd0, 1'b1, 11'd1, 1'b0);
        drain_results();
    endtask

    // Random chains: mostly grown and cut from known heads, with some noise.
    task automatic test_random(int n);
        logic [1:0]        o;
        logic [BLK_W-1:0]  h;
        logic              p;
        logic [LINK_W-1:0] c;
        logic              g;
        int                sel;
        for (int k = 0; k < n; k++)
        begin
            sel = $urandom_range(0, 99);
            o   = (sel < 15) ? OP_ALLOC : (sel < 65) ? OP_SEEK : (sel < 95) ? OP_CUT : OP_NONE;
            g   = 1'($urandom_range(0, 1));
            c   = LINK_W'(($urandom_range(0, 49) == 0) ? $urandom_range(0, 1024)
                                                       : $urandom_range(0, 12));
            if (o == OP_CUT && $urandom_range(0, 3) == 0)
                c = 0;
            h = BLK_W'($urandom_range(0, NUM_BLOCKS - 1));
            p = 1'b0;
            if ($urandom_range(0, 9) != 0)
            begin
                if (known_heads.size() != 0 && $urandom_range(0, 3) != 0)
                begin
                    h = BLK_W'(known_heads[$urandom_range(0, known_heads.size() - 1)]);
                    p = 1'b1;
                end
                else if (ever_taken[h])
                    p = 1'b1;
            end
            send_request(o, h, p, c, g);
            if (k == n / 2)
                drain_results();
        end
    endtask

    initial
    begin
        error_count  = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        op           = OP_ALLOC;
        head_block   = '0;
        head_present = 1'b0;
        count        = '0;
        grow         = 1'b0;
        for (int i = 0; i < NUM_BLOCKS; i++)
        begin
            used_mark[i]  = 1'b0;
            chain_link[i] = 0;
            ever_taken[i] = 1'b0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(1200);
        drain_results();
        repeat (200) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #200ms;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== block_chain_allocator_core.f =====
rtl/bca_pkg.sv
rtl/bca_ram.sv
rtl/bca_datapath.sv
rtl/bca_ctrl.sv
rtl/block_chain_allocator_core.sv
sim/testbench.sv
